### rtl/bfcm_pkg.sv
// ----------------------------------------------------------------------------
// bfcm_pkg: shared definitions of the box filter clipped mean block
// Holds the store geometry, command and register codes, and the divider
// request and response types.
// ----------------------------------------------------------------------------
package bfcm_pkg;

	localparam int MAX_WIDTH    = 256;
	localparam int MAX_HEIGHT   = 256;
	localparam int MAX_KERNEL   = 15;
	localparam int MAX_CHANNELS = 4;

	localparam int ADDR_W = $clog2(MAX_WIDTH * MAX_HEIGHT);
	localparam int SUM_W  = 16;
	localparam int CNT_W  = 8;
	localparam int QUO_W  = 8;
	localparam int QBIT_W = $clog2(QUO_W);

	localparam logic CMD_LOAD   = 1'b0;
	localparam logic CMD_FILTER = 1'b1;

	localparam logic [3:0] REG_IMAGE_WIDTH   = 4'd0;
	localparam logic [3:0] REG_IMAGE_HEIGHT  = 4'd1;
	localparam logic [3:0] REG_KERNEL_WIDTH  = 4'd2;
	localparam logic [3:0] REG_KERNEL_HEIGHT = 4'd3;
	localparam logic [3:0] REG_ANCHOR_COL    = 4'd4;
	localparam logic [3:0] REG_ANCHOR_ROW    = 4'd5;
	localparam logic [3:0] REG_CENTERED      = 4'd6;
	localparam logic [3:0] REG_CHANNEL_COUNT = 4'd7;

	typedef struct packed {
		logic             start;
		logic [SUM_W-1:0] dividend;
		logic [CNT_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [QUO_W-1:0] quotient;
	} div_rsp_t;

endpackage

### rtl/bfcm_div.sv
// ----------------------------------------------------------------------------
// bfcm_div: serial restoring divider
// Divides a channel sum by the pixel count, one quotient bit per cycle.
// The quotient is known to fit in eight bits.
// ----------------------------------------------------------------------------
module bfcm_div
	import bfcm_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [SUM_W-1:0]  rem_q;
	logic [CNT_W-1:0]  den_q;
	logic [QUO_W-1:0]  quo_q;
	logic [QBIT_W-1:0] bit_q;
	logic              busy_q;
	logic              done_q;
	logic [SUM_W-1:0]  trial;

	assign trial = SUM_W'(den_q) << bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			bit_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				rem_q  <= req.dividend;
				den_q  <= req.divisor;
				quo_q  <= '0;
				bit_q  <= QBIT_W'(QUO_W - 1);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (rem_q >= trial) begin
					rem_q        <= rem_q - trial;
					quo_q[bit_q] <= 1'b1;
				end
				if (bit_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					bit_q <= bit_q - 1'b1;
				end
			end
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

### rtl/box_filter_clipped_mean_top.sv
// ----------------------------------------------------------------------------
// box_filter_clipped_mean_top: box filter mean blur over a frame store
// A load word writes one four-channel pixel into the store; a filter word
// averages the in-image pixels of the kernel window around a pixel.
// ----------------------------------------------------------------------------
// A load word gives no result. A filter word is accepted, then reads each
// window pixel in turn through the single frame-store read port, drains the
// last read, divides each of the four channel sums in turn in the one shared
// serial divider, and moves the result to the output register before the
// input is ready again. A window with no in-image pixel skips the divider,
// and a filter word outside the image or with an empty window goes straight
// to the output step. A result not yet taken holds the block in its last
// step. The frame store holds 65536 words of 32 bits and is not cleared; the
// whole image must be loaded before filtering. The result waits in an output
// register, so the input side reopens while it is not yet taken.
module box_filter_clipped_mean_top
	import bfcm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// Fields from bit 0: row, col, in_chan0, in_chan1, in_chan2, in_chan3.
	input  logic [47:0] s_axis_tdata,
	// Fields from bit 0: command.
	input  logic        s_axis_tuser,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// Fields from bit 0: out_chan0, out_chan1, out_chan2, out_chan3, pixels_used.
	output logic [39:0] m_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_index,
	input  logic [8:0]  cfg_data
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DIVGO,
		ST_DIVWAIT,
		ST_OUT
	} state_t;

	state_t state_q;

	logic [8:0] image_width_q;
	logic [8:0] image_height_q;
	logic [3:0] kernel_width_q;
	logic [3:0] kernel_height_q;
	logic [3:0] anchor_col_q;
	logic [3:0] anchor_row_q;
	logic       centered_q;
	logic [2:0] channel_count_q;

	logic [8:0] w_sat;
	logic [8:0] h_sat;
	logic [2:0] nch_sat;
	logic [3:0] off_r;
	logic [3:0] off_c;

	logic       cmd;
	logic [7:0] row;
	logic [7:0] col;
	logic       in_accept;
	logic       in_image;

	logic signed [9:0] r_q;
	logic signed [9:0] c_q;
	logic signed [9:0] left_q;
	logic [3:0]        m_q;
	logic [3:0]        n_q;
	logic              pix_in;
	logic              valid_s1;

	logic [31:0] frame_store_q [MAX_WIDTH * MAX_HEIGHT];
	logic [31:0] rd_data_s1;
	logic        store_we;

	logic [SUM_W-1:0] sum_q [MAX_CHANNELS];
	logic [CNT_W-1:0] count_q;
	logic [QUO_W-1:0] mean_q [MAX_CHANNELS];
	logic [1:0]       ch_q;
	logic             div_start_q;
	logic [39:0]      out_data_q;
	logic             out_valid_q;
	logic [39:0]      out_next;

	div_req_t div_req;
	div_rsp_t div_rsp;

	assign w_sat   = (image_width_q > 9'(MAX_WIDTH)) ? 9'(MAX_WIDTH) : image_width_q;
	assign h_sat   = (image_height_q > 9'(MAX_HEIGHT)) ? 9'(MAX_HEIGHT) : image_height_q;
	assign nch_sat = (channel_count_q > 3'(MAX_CHANNELS)) ? 3'(MAX_CHANNELS)
	                                                      : channel_count_q;
	assign off_r   = centered_q ? (kernel_height_q >> 1) : anchor_row_q;
	assign off_c   = centered_q ? (kernel_width_q >> 1) : anchor_col_q;

	assign cmd       = s_axis_tuser;
	assign row       = s_axis_tdata[7:0];
	assign col       = s_axis_tdata[15:8];
	assign in_accept = s_axis_tvalid && s_axis_tready;
	assign in_image  = ({1'b0, row} < h_sat) && ({1'b0, col} < w_sat);

	assign s_axis_tready = (state_q == ST_IDLE);
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	assign pix_in = !r_q[9] && (r_q[8:0] < h_sat) && !c_q[9] && (c_q[8:0] < w_sat);
	assign store_we = in_accept && (cmd == CMD_LOAD) && in_image;

	always_ff @(posedge clk) begin
		if (store_we) begin
			frame_store_q[{row, col}] <= s_axis_tdata[47:16];
		end
		rd_data_s1 <= frame_store_q[ADDR_W'({r_q[7:0], c_q[7:0]})];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q   <= 9'd256;
			image_height_q  <= 9'd256;
			kernel_width_q  <= 4'd3;
			kernel_height_q <= 4'd3;
			anchor_col_q    <= 4'd0;
			anchor_row_q    <= 4'd0;
			centered_q      <= 1'b1;
			channel_count_q <= 3'd3;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:   image_width_q   <= cfg_data;
				REG_IMAGE_HEIGHT:  image_height_q  <= cfg_data;
				REG_KERNEL_WIDTH:  kernel_width_q  <= cfg_data[3:0];
				REG_KERNEL_HEIGHT: kernel_height_q <= cfg_data[3:0];
				REG_ANCHOR_COL:    anchor_col_q    <= cfg_data[3:0];
				REG_ANCHOR_ROW:    anchor_row_q    <= cfg_data[3:0];
				REG_CENTERED:      centered_q      <= cfg_data[0];
				REG_CHANNEL_COUNT: channel_count_q <= cfg_data[2:0];
				default: begin
				end
			endcase
		end
	end

	assign div_req.start    = div_start_q;
	assign div_req.dividend = sum_q[ch_q];
	assign div_req.divisor  = count_q;

	bfcm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_comb begin
		out_next = '0;
		for (int k = 0; k < MAX_CHANNELS; k++) begin
			if ((count_q != '0) && (3'(k) < nch_sat)) begin
				out_next[8*k +: 8] = mean_q[k];
			end
		end
		out_next[39:32] = count_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			valid_s1    <= 1'b0;
			div_start_q <= 1'b0;
			out_valid_q <= 1'b0;
			count_q     <= '0;
			ch_q        <= '0;
			m_q         <= '0;
			n_q         <= '0;
		end else begin
			if (out_valid_q && m_axis_tready && (state_q != ST_OUT)) begin
				out_valid_q <= 1'b0;
			end
			valid_s1 <= (state_q == ST_SCAN) && pix_in;
			if (valid_s1) begin
				for (int k = 0; k < MAX_CHANNELS; k++) begin
					sum_q[k] <= sum_q[k] + SUM_W'(rd_data_s1[8*k +: 8]);
				end
				count_q <= count_q + 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_accept && (cmd == CMD_FILTER)) begin
						count_q <= '0;
						for (int k = 0; k < MAX_CHANNELS; k++) begin
							sum_q[k] <= '0;
						end
						r_q    <= $signed({2'b00, row}) - $signed({6'b0, off_r});
						c_q    <= $signed({2'b00, col}) - $signed({6'b0, off_c});
						left_q <= $signed({2'b00, col}) - $signed({6'b0, off_c});
						m_q    <= '0;
						n_q    <= '0;
						ch_q   <= '0;
						if (!in_image || (kernel_width_q == '0) || (kernel_height_q == '0)) begin
							state_q <= ST_OUT;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (n_q == kernel_width_q - 1'b1) begin
						n_q <= '0;
						c_q <= left_q;
						if (m_q == kernel_height_q - 1'b1) begin
							state_q <= ST_DRAIN;
						end else begin
							m_q <= m_q + 1'b1;
							r_q <= r_q + 10'sd1;
						end
					end else begin
						n_q <= n_q + 1'b1;
						c_q <= c_q + 10'sd1;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_DIVGO;
				end
				ST_DIVGO: begin
					if (count_q == '0) begin
						state_q <= ST_OUT;
					end else begin
						div_start_q <= 1'b1;
						state_q     <= ST_DIVWAIT;
					end
				end
				ST_DIVWAIT: begin
					div_start_q <= 1'b0;
					if (div_rsp.done) begin
						mean_q[ch_q] <= div_rsp.quotient;
						if (ch_q == 2'(MAX_CHANNELS - 1)) begin
							state_q <= ST_OUT;
						end else begin
							ch_q    <= ch_q + 1'b1;
							state_q <= ST_DIVGO;
						end
					end
				end
				ST_OUT: begin
					if (!out_valid_q || m_axis_tready) begin
						out_data_q  <= out_next;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_read_from_scan: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> $past(state_q == ST_SCAN))
		else $error("window read valid outside the scan");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_KERNEL * MAX_KERNEL))
		else $error("pixel count exceeds the largest window");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT) && out_valid_q && !m_axis_tready |=> (state_q == ST_OUT))
		else $error("result overwrote a word not yet taken");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_DIVWAIT))
		else $error("divider finished outside a divide step");

endmodule

### tb/box_filter_clipped_mean_top_test.sv
// ----------------------------------------------------------------------------
// box_filter_clipped_mean_top_test: self-checking bench of the box filter
// Loads small images into the frame store and filters pixels under many
// register settings, first from a directed table, then at random. Results
// are compared field by field with a window-mean predictor or a pinned value.
// ----------------------------------------------------------------------------
module box_filter_clipped_mean_top_test;
	import bfcm_pkg::*;

	localparam int CLK_PERIOD     = 8;
	localparam int SETTLE_CYCLES  = 300;
	localparam int TIMEOUT_CYCLES = 4_000_000;
	localparam int RANDOM_WORDS   = 1325;
	localparam int PLAN_LEN       = 50;
	localparam logic [3:0] REG_UNUSED = 4'd12;

	typedef struct packed {
		logic [7:0] pixels_used;
		logic [7:0] chan3, chan2, chan1, chan0;
	} blur_result_t;

	typedef enum logic {STEP_REG, STEP_WORD} step_kind_t;

	typedef struct packed {
		step_kind_t   kind;
		logic [3:0]   idx;
		logic [8:0]   val;
		logic         cmd;
		logic [7:0]   row;
		logic [7:0]   col;
		logic [31:0]  pix;
		logic         pin;
		blur_result_t want;
	} plan_step_t;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	// Fields from bit 0: row, col, in_chan0, in_chan1, in_chan2, in_chan3.
	logic [47:0] s_axis_tdata  = '0;
	// Fields from bit 0: command.
	logic        s_axis_tuser  = CMD_LOAD;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	// Fields from bit 0: out_chan0, out_chan1, out_chan2, out_chan3, pixels_used.
	logic [39:0] m_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic        cfg_valid     = 1'b0;
	logic        cfg_ready;
	logic [3:0]  cfg_index     = '0;
	logic [8:0]  cfg_data      = '0;

	logic [8:0]  img_cols    = 9'd256;
	logic [8:0]  img_rows    = 9'd256;
	logic [3:0]  win_cols    = 4'd3;
	logic [3:0]  win_rows    = 4'd3;
	logic [3:0]  anchor_c    = 4'd0;
	logic [3:0]  anchor_r    = 4'd0;
	logic        centered_on = 1'b1;
	logic [2:0]  chan_count  = 3'd3;

	logic [31:0]  frame_copy [MAX_WIDTH * MAX_HEIGHT];
	bit           loaded     [MAX_WIDTH * MAX_HEIGHT];
	blur_result_t blur_expected [$];
	int           mismatches   = 0;
	int           words_sent   = 0;
	int           src_idle_pct = 18;
	int           snk_idle_pct = 83;
	string        field_names [5] = '{"out_chan0", "out_chan1", "out_chan2", "out_chan3",
		"pixels_used"};

	plan_step_t directed_plan [PLAN_LEN] = '{
		'{STEP_REG,  REG_IMAGE_WIDTH,   9'd2,   CMD_LOAD,   8'd0,   8'd0,   32'h0, 1'b0, 40'h0},
		'{STEP_REG,  REG_IMAGE_HEIGHT,  9'd2,   CMD_LOAD,   8'd0,   8'd0,   32'h0, 1'b0, 40'h0},
		'{STEP_WORD, REG_IMAGE_WIDTH,   9'd0,   CMD_LOAD,   8'd0,   8'd0,   32'hffffffff, 1'b0,
			40'h0},
		'{STEP_WORD, REG_IMAGE_WIDTH,   9'd0,   CMD_LOAD,   8'd0,   8'd1,   32'h00000000, 1'b0,
			40'h0},
		'{STEP_WORD, REG_IMAGE_WIDTH,   9'd0,   CMD_LOAD,   8'd1,   8'd0,   32'h04030201, 1'b0,
			40'h0},
		'{STEP_WORD, REG_IMAGE_WIDTH,   9'd0,   CMD_LOAD,   8'd1,   8'd1,   32'h7f80c0fe, 1'b0,
			40'h0},
		'{STEP_WORD, REG_IMAGE_WIDTH,   9'd0,   CMD_LOAD,   8'd5,   8'd5,   32'h11223344, 1'b0,
			40'h0},
		'{STEP_WORD, REG_IMAGE_WIDTH,   9'd0,   CMD_FILTER, 8'd0,   8'd0,   32'h0, 1'b0, 40'h0},
		'{STEP_WORD, REG_IMAGE_WIDTH,   9'd0,   CMD_FILTER, 8'd1,   8'd1,   32'h0, 1'b0, 40'h0},
		'{STEP_WORD, REG_IMAGE_WIDTH,   9'd0,   CMD_FILTER, 8'd2,   8'd0,   32'h0, 1'b1, 40'h0},
		'{STEP_WORD, REG_IMAGE_WIDTH,   9'd0,   CMD_FILTER, 8'd255, 8'd255, 32'h0, 1'b1, 40'h0},
		'{STEP_WORD, REG_IMAGE_WIDTH,   9'd0,   CMD_FILTER, 8'd0,   8'd2,   32'h0, 1'b1, 40'h0},
		'{STEP_REG,  REG_KERNEL_WIDTH,  9'd1,   CMD_LOAD,   8'd0,   8'd0,   32'h0, 1'b0, 40'h0},
		'{STEP_REG,  REG_KERNEL_HEIGHT, 9'd1,   CMD_LOAD,   8'd0,   8'd0,   32'h0, 1'b0, 40'h0},
		'{STEP_REG,  REG_CHANNEL_COUNT, 9'd4,   CMD_LOAD,   8'd0,   8'd0,   32'h0, 1'b0, 40'h0},
		'{STEP_REG,  REG_CENTERED,      9'd0,   CMD_LOAD,   8'd0,   8'd0,   32'h0, 1'b0, 40'h0},
		'{STEP_WORD, REG_IMAGE_WIDTH,   9'd0,   CMD_FILTER, 8'd0,   8'd0,   32'h0, 1'b1,
			40'h01_ffffffff},
		'{STEP_WORD, REG_IMAGE_WIDTH,   9'd0,   CMD_FILTER, 8'd0,   8'd1,   32'h0, 1'b1,
			40'h01_00000000},
		'{STEP_REG,  REG_KERNEL_WIDTH,  9'd0,   CMD_LOAD,   8'd0,   8'd0,   32'h0, 1'b0, 40'h0},
		'{STEP_WORD, REG_IMAGE_WIDTH,   9'd0,   CMD_FILTER, 8'd1,   8'd1,   32'h0, 1'b1, 40'h0},
		'{STEP_REG,  REG_KERNEL_WIDTH,  9'd15,  CMD_LOAD,   8'd0,   8'd0,   32'h0, 1'b0, 40'h0},
		'{STEP_REG,  REG_KERNEL_HEIGHT, 9'd15,  CMD_LOAD,   8'd0,   8'd0,   32'h0, 1'b0, 40'h0},
		'{STEP_REG,  REG_ANCHOR_COL,    9'd14,  CMD_LOAD,   8'd0,   8'd0,   32'h0, 1'b0, 40'h0},
		'{STEP_REG,  REG_ANCHOR_ROW,    9'd14,  CMD_LOAD,   8'd0,   8'd0,   32'h0, 1'b0, 40'h0},
		'{STEP_REG,  REG_CHANNEL_COUNT, 9'd7,   CMD_LOAD,   8'd0,   8'd0,   32'h0, 1'b0, 40'h0},
		'{STEP_WORD, REG_IMAGE_WIDTH,   9'd0,   CMD_FILTER, 8'd1,   8'd1,   32'h0, 1'b0, 40'h0},
		'{STEP_WORD, REG_IMAGE_WIDTH,   9'd0,   CMD_FILTER, 8'd0,   8'd0,   32'h0, 1'b0, 40'h0},
		'{STEP_REG,  REG_ANCHOR_COL,    9'd15,  CMD_LOAD,   8'd0,   8'd0,   32'h0, 1'b0, 40'h0},
		'{STEP_REG,  REG_ANCHOR_ROW,    9'd15,  CMD_LOAD,   8'd0,   8'd0,   32'h0, 1'b0, 40'h0},
		'{STEP_WORD, REG_IMAGE_WIDTH,   9'd0,   CMD_FILTER, 8'd0,   8'd0,   32'h0, 1'b1, 40'h0},
		'{STEP_WORD, REG_IMAGE_WIDTH,   9'd0,   CMD_FILTER, 8'd1,   8'd1,   32'h0, 1'b0, 40'h0},
		'{STEP_REG,  REG_CHANNEL_COUNT, 9'd0,   CMD_LOAD,   8'd0,   8'd0,   32'h0, 1'b0, 40'h0},
		'{STEP_REG,  REG_KERNEL_WIDTH,  9'd1,   CMD_LOAD,   8'd0,   8'd0,   32'h0, 1'b0, 40'h0},
		'{STEP_REG,  REG_KERNEL_HEIGHT, 9'd1,   CMD_LOAD,   8'd0,   8'd0,   32'h0, 1'b0, 40'h0},
		'{STEP_REG,  REG_ANCHOR_COL,    9'd0,   CMD_LOAD,   8'd0,   8'd0,   32'h0, 1'b0, 40'h0},
		'{STEP_REG,  REG_ANCHOR_ROW,    9'd0,   CMD_LOAD,   8'd0,   8'd0,   32'h0, 1'b0, 40'h0},
		'{STEP_WORD, REG_IMAGE_WIDTH,   9'd0,   CMD_FILTER, 8'd1,   8'd0,   32'h0, 1'b1,
			40'h01_00000000},
		'{STEP_REG,  REG_CENTERED,      9'd1,   CMD_LOAD,   8'd0,   8'd0,   32'h0, 1'b0, 40'h0},
		'{STEP_REG,  REG_IMAGE_WIDTH,   9'd0,   CMD_LOAD,   8'd0,   8'd0,   32'h0, 1'b0, 40'h0},
		'{STEP_WORD, REG_IMAGE_WIDTH,   9'd0,   CMD_FILTER, 8'd0,   8'd0,   32'h0, 1'b1, 40'h0},
		'{STEP_REG,  REG_UNUSED,        9'h1ff, CMD_LOAD,   8'd0,   8'd0,   32'h0, 1'b0, 40'h0},
		'{STEP_REG,  REG_IMAGE_WIDTH,   9'd2,   CMD_LOAD,   8'd0,   8'd0,   32'h0, 1'b0, 40'h0},
		'{STEP_REG,  REG_CHANNEL_COUNT, 9'd1,   CMD_LOAD,   8'd0,   8'd0,   32'h0, 1'b0, 40'h0},
		'{STEP_WORD, REG_IMAGE_WIDTH,   9'd0,   CMD_FILTER, 8'd1,   8'd0,   32'h0, 1'b1,
			40'h01_00000001},
		'{STEP_REG,  REG_IMAGE_HEIGHT,  9'd0,   CMD_LOAD,   8'd0,   8'd0,   32'h0, 1'b0, 40'h0},
		'{STEP_WORD, REG_IMAGE_WIDTH,   9'd0,   CMD_LOAD,   8'd0,   8'd0,   32'h55aa55aa, 1'b0,
			40'h0},
		'{STEP_REG,  REG_IMAGE_HEIGHT,  9'd2,   CMD_LOAD,   8'd0,   8'd0,   32'h0, 1'b0, 40'h0},
		'{STEP_WORD, REG_IMAGE_WIDTH,   9'd0,   CMD_FILTER, 8'd0,   8'd0,   32'h0, 1'b1,
			40'h01_000000ff},
		'{STEP_REG,  REG_IMAGE_WIDTH,   9'h1ff, CMD_LOAD,   8'd0,   8'd0,   32'h0, 1'b0, 40'h0},
		'{STEP_WORD, REG_IMAGE_WIDTH,   9'd0,   CMD_FILTER, 8'd0,   8'd1,   32'h0, 1'b1,
			40'h01_00000000}
	};

	box_filter_clipped_mean_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
	end

	function automatic int used_cols();
		return (img_cols > MAX_WIDTH) ? MAX_WIDTH : int'(img_cols);
	endfunction

	function automatic int used_rows();
		return (img_rows > MAX_HEIGHT) ? MAX_HEIGHT : int'(img_rows);
	endfunction

	function automatic blur_result_t window_mean(input logic [7:0] row, input logic [7:0] col);
		int          w, h, kw, kh, nch, top, left, r, c, m, n, k;
		int unsigned sums [4];
		int unsigned npix;
		logic [31:0] px;
		logic [31:0] means;
		w = used_cols();
		h = used_rows();
		npix = 0;
		means = '0;
		for (k = 0; k < 4; k++)
			sums[k] = 0;
		if (int'(row) >= h || int'(col) >= w)
			return '0;
		kw  = (win_cols > MAX_KERNEL) ? MAX_KERNEL : int'(win_cols);
		kh  = (win_rows > MAX_KERNEL) ? MAX_KERNEL : int'(win_rows);
		nch = (chan_count > MAX_CHANNELS) ? MAX_CHANNELS : int'(chan_count);
		if (centered_on) begin
			top  = int'(row) - kh / 2;
			left = int'(col) - kw / 2;
		end else begin
			top  = int'(row) - int'(anchor_r);
			left = int'(col) - int'(anchor_c);
		end
		for (m = 0; m < kh; m++) begin
			r = top + m;
			if (r >= 0 && r < h) begin
				for (n = 0; n < kw; n++) begin
					c = left + n;
					if (c >= 0 && c < w) begin
						px = frame_copy[r * MAX_WIDTH + c];
						npix++;
						for (k = 0; k < 4; k++)
							sums[k] += px[8*k +: 8];
					end
				end
			end
		end
		if (npix == 0)
			return '0;
		for (k = 0; k < nch; k++)
			means[8*k +: 8] = 8'(sums[k] / npix);
		return {npix[7:0], means};
	endfunction

	task automatic write_reg(input logic [3:0] idx, input logic [8:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_IMAGE_WIDTH:   img_cols    = val;
			REG_IMAGE_HEIGHT:  img_rows    = val;
			REG_KERNEL_WIDTH:  win_cols    = val[3:0];
			REG_KERNEL_HEIGHT: win_rows    = val[3:0];
			REG_ANCHOR_COL:    anchor_c    = val[3:0];
			REG_ANCHOR_ROW:    anchor_r    = val[3:0];
			REG_CENTERED:      centered_on = val[0];
			REG_CHANNEL_COUNT: chan_count  = val[2:0];
			default: ;
		endcase
	endtask

	task automatic send_word(input logic cmd, input logic [7:0] row, input logic [7:0] col,
			input logic [31:0] pix, input logic pin, input blur_result_t pinned);
		int addr;
		cfg_valid <= 1'b0;
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= cmd;
		s_axis_tdata  <= {pix, col, row};
		do @(posedge clk); while (!s_axis_tready);
		addr = int'(row) * MAX_WIDTH + int'(col);
		if (cmd == CMD_FILTER) begin
			blur_expected = {blur_expected, (pin ? pinned : window_mean(row, col))};
		end else if (int'(row) < used_rows() && int'(col) < used_cols()) begin
			frame_copy[addr] = pix;
			loaded[addr] = 1'b1;
		end
		words_sent++;
	endtask

	// Loads leave no result behind, so the extra cycles cover one still in flight.
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (blur_expected.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic run_phase(input int n_words);
		int         pick, w, h, r, c, i;
		logic [8:0] w_reg, h_reg;
		drain_results();
		pick = $urandom_range(19);
		w_reg = 9'($urandom_range(1, 10));
		h_reg = 9'($urandom_range(1, 10));
		if (pick == 0) begin
			w_reg = $urandom_range(1) ? 9'd256 : 9'($urandom_range(257, 511));
			h_reg = 9'd1;
		end else if (pick == 1) begin
			w_reg = 9'd1;
			h_reg = $urandom_range(1) ? 9'd256 : 9'($urandom_range(257, 511));
		end else if (pick == 2) begin
			if ($urandom_range(1))
				w_reg = 9'd0;
			else
				h_reg = 9'd0;
		end
		write_reg(REG_IMAGE_WIDTH, w_reg);
		write_reg(REG_IMAGE_HEIGHT, h_reg);
		write_reg(REG_KERNEL_WIDTH, ($urandom_range(9) == 0) ? 9'd0 : 9'($urandom_range(1, 15)));
		write_reg(REG_KERNEL_HEIGHT, ($urandom_range(9) == 0) ? 9'd0 : 9'($urandom_range(1, 15)));
		write_reg(REG_ANCHOR_COL, 9'($urandom_range(15)));
		write_reg(REG_ANCHOR_ROW, 9'($urandom_range(15)));
		write_reg(REG_CENTERED, 9'($urandom_range(1)));
		write_reg(REG_CHANNEL_COUNT, 9'($urandom_range(7)));
		w = used_cols();
		h = used_rows();
		for (r = 0; r < h; r++)
			for (c = 0; c < w; c++)
				if (!loaded[r * MAX_WIDTH + c])
					send_word(CMD_LOAD, 8'(r), 8'(c), $urandom, 1'b0, '0);
		for (i = 0; i < n_words; i++) begin
			if (w > 0 && h > 0 && $urandom_range(99) < 80) begin
				r = $urandom_range(0, h - 1);
				c = $urandom_range(0, w - 1);
			end else begin
				r = $urandom_range(255);
				c = $urandom_range(255);
			end
			if ($urandom_range(99) < 65)
				send_word(CMD_FILTER, 8'(r), 8'(c), $urandom, 1'b0, '0);
			else
				send_word(CMD_LOAD, 8'(r), 8'(c), $urandom, 1'b0, '0);
		end
	endtask

	always @(posedge clk) begin
		logic [39:0] want, got;
		int          k;
		if (m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata;
			if (blur_expected.size() == 0) begin
				$display("%0t: result word %h arrived with no filter word pending", $time, got);
				mismatches++;
			end else begin
				want = blur_expected.pop_front();
				for (k = 0; k < 5; k++) begin
					if (got[8*k +: 8] !== want[8*k +: 8]) begin
						$display("%0t: %s expected %0d, got %0d", $time, field_names[k],
							want[8*k +: 8], got[8*k +: 8]);
						mismatches++;
					end
				end
			end
		end
	end

	initial begin
		int regime, goal;
		bit prev_word;
		prev_word = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		foreach (directed_plan[s]) begin
			if (directed_plan[s].kind == STEP_REG) begin
				if (prev_word)
					drain_results();
				write_reg(directed_plan[s].idx, directed_plan[s].val);
				prev_word = 1'b0;
			end else begin
				send_word(directed_plan[s].cmd, directed_plan[s].row, directed_plan[s].col,
					directed_plan[s].pix, directed_plan[s].pin, directed_plan[s].want);
				prev_word = 1'b1;
			end
		end
		for (regime = 0; regime < 3; regime++) begin
			src_idle_pct = (regime == 0) ? 18 : (regime == 1) ? 83 : 0;
			snk_idle_pct = (regime == 0) ? 83 : (regime == 1) ? 18 : 0;
			goal = words_sent + RANDOM_WORDS / 3;
			while (words_sent < goal)
				run_phase($urandom_range(20, 50));
		end
		drain_results();
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#(CLK_PERIOD * TIMEOUT_CYCLES);
		$display("Timed out waiting for the block");
		$display("Some tests failed");
		$finish;
	end

endmodule

### filelist.f
rtl/bfcm_pkg.sv
rtl/bfcm_div.sv
rtl/box_filter_clipped_mean_top.sv
tb/box_filter_clipped_mean_top_test.sv
